// File: sv/sdba_pkg.sv
// Shared types, codes and constants of the signed decimal BCD arithmetic unit.
`default_nettype none
package sdba_pkg;

  localparam int FW = 60;
  localparam int NW = 48;

  typedef enum logic [2:0] {
    M_ADD  = 3'd0,
    M_SUB  = 3'd1,
    M_MUL  = 3'd2,
    M_DIV  = 3'd3,
    M_REM  = 3'd4,
    M_CONV = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0] mode;
    logic       aneg;
    logic       nneg;
    logic       err;
    logic       div0;
    logic       addovf;
    logic       addneg;
  } ctl_t;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: sv/sdba_in_if.sv
// Request channel carrying one operation word.
`default_nettype none
interface sdba_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [1:0]  a_sign;
  logic [59:0]        a_digits;
  logic signed [1:0]  b_sign;
  logic [59:0]        b_digits;
  logic signed [47:0] b_binary;

  modport source (output valid, mode, a_sign, a_digits, b_sign, b_digits, b_binary,
                  input ready);
  modport sink (input valid, mode, a_sign, a_digits, b_sign, b_digits, b_binary,
                output ready);
endinterface
`default_nettype wire

// File: sv/sdba_out_if.sv
// Response channel carrying one result word.
`default_nettype none
interface sdba_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] r_sign;
  logic [59:0]       r_digits;
  logic [1:0]        status;

  modport source (output valid, r_sign, r_digits, status, input ready);
  modport sink (input valid, r_sign, r_digits, status, output ready);
endinterface
`default_nettype wire

// File: sv/sdba_dec_cell.sv
// One cell of the BCD to binary chain: folds one digit of each operand.
`default_nettype none
module sdba_dec_cell #(
  parameter int DIGITS = 15,
  parameter int IDX    = 0,
  parameter int AW     = 50,
  parameter int SW     = 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [4*DIGITS-1:0]   a_raw_i,
  input  wire logic [4*DIGITS-1:0]   b_raw_i,
  input  wire logic [AW-1:0]         acc_a_i,
  input  wire logic [AW-1:0]         acc_b_i,
  input  wire logic                  bad_a_i,
  input  wire logic                  bad_b_i,
  input  wire logic [SW-1:0]         side_i,
  output logic                       valid_o,
  output logic [4*DIGITS-1:0]        a_raw_o,
  output logic [4*DIGITS-1:0]        b_raw_o,
  output logic [AW-1:0]              acc_a_o,
  output logic [AW-1:0]              acc_b_o,
  output logic                       bad_a_o,
  output logic                       bad_b_o,
  output logic [SW-1:0]              side_o
);

  logic [3:0]    nib_a, nib_b;
  logic [AW-1:0] acc_a_d, acc_b_d;
  logic          valid_q;

  assign nib_a   = a_raw_i[4*IDX +: 4];
  assign nib_b   = b_raw_i[4*IDX +: 4];
  assign acc_a_d = (acc_a_i << 3) + (acc_a_i << 1) + AW'(nib_a);
  assign acc_b_d = (acc_b_i << 3) + (acc_b_i << 1) + AW'(nib_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_raw_o <= a_raw_i;
      b_raw_o <= b_raw_i;
      acc_a_o <= acc_a_d;
      acc_b_o <= acc_b_d;
      bad_a_o <= bad_a_i | (nib_a > 4'd9);
      bad_b_o <= bad_b_i | (nib_b > 4'd9);
      side_o  <= side_i;
    end
  end

  assign valid_o = valid_q;

endmodule
`default_nettype wire

// File: sv/sdba_core_cell.sv
// One cell of the core chain: a modular multiply step and a restoring divide step.
`default_nettype none
module sdba_core_cell
  import sdba_pkg::*;
#(
  parameter int DIGITS = 15,
  parameter int W      = 50,
  parameter int K      = 0,
  parameter int SW     = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [$clog2(pow10(DIGITS))-1:0] r_i,
  input  wire logic               ovf_i,
  input  wire logic [W-1:0]       rem_i,
  input  wire logic [W-1:0]       q_i,
  input  wire logic [W-1:0]       dvd_i,
  input  wire logic [W-1:0]       dvs_i,
  input  wire logic [$clog2(pow10(DIGITS))-1:0] mula_i,
  input  wire logic [NW-1:0]      muln_i,
  input  wire logic [SW-1:0]      side_i,
  output logic                    valid_o,
  output logic [$clog2(pow10(DIGITS))-1:0] r_o,
  output logic                    ovf_o,
  output logic [W-1:0]            rem_o,
  output logic [W-1:0]            q_o,
  output logic [W-1:0]            dvd_o,
  output logic [W-1:0]            dvs_o,
  output logic [$clog2(pow10(DIGITS))-1:0] mula_o,
  output logic [NW-1:0]           muln_o,
  output logic [SW-1:0]           side_o
);

  localparam logic [63:0] MOD = pow10(DIGITS);
  localparam int          AW  = $clog2(MOD);
  localparam logic [AW:0] MODX = (AW+1)'(MOD);

  logic          nbit;
  logic [AW:0]   t1, t1m, t2, t2m;
  logic          s1, s2;
  logic [W:0]    rr;
  logic          ge;
  logic [W-1:0]  rem_d, q_d;
  logic          valid_q;

  if (K < NW) begin : g_nbit
    assign nbit = muln_i[K];
  end else begin : g_nozero
    assign nbit = 1'b0;
  end

  always_comb begin
    t1  = {r_i, 1'b0};
    s1  = t1 >= MODX;
    t1m = s1 ? t1 - MODX : t1;
    t2  = t1m + {1'b0, mula_i};
    s2  = nbit && (t2 >= MODX);
    if (!nbit) begin
      t2m = t1m;
    end else if (s2) begin
      t2m = t2 - MODX;
    end else begin
      t2m = t2;
    end
    rr    = {rem_i, dvd_i[K]};
    ge    = rr >= {1'b0, dvs_i};
    rem_d = ge ? W'(rr - {1'b0, dvs_i}) : rr[W-1:0];
    q_d   = q_i;
    q_d[K] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o    <= t2m[AW-1:0];
      ovf_o  <= ovf_i | s1 | s2;
      rem_o  <= rem_d;
      q_o    <= q_d;
      dvd_o  <= dvd_i;
      dvs_o  <= dvs_i;
      mula_o <= mula_i;
      muln_o <= muln_i;
      side_o <= side_i;
    end
  end

  assign valid_o = valid_q;

endmodule
`default_nettype wire

// File: sv/sdba_dd_cell.sv
// One cell of the binary to BCD chain: adjusts every digit and shifts in one bit.
`default_nettype none
module sdba_dd_cell #(
  parameter int DIGITS = 15,
  parameter int AW     = 50,
  parameter int K      = 0,
  parameter int SW     = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [AW-1:0]       bin_i,
  input  wire logic [4*DIGITS-1:0] bcd_i,
  input  wire logic [SW-1:0]       side_i,
  output logic                     valid_o,
  output logic [AW-1:0]            bin_o,
  output logic [4*DIGITS-1:0]      bcd_o,
  output logic [SW-1:0]            side_o
);

  logic [4*DIGITS-1:0] adj;
  logic                valid_q;

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      adj[4*d +: 4] = (bcd_i[4*d +: 4] >= 4'd5) ? bcd_i[4*d +: 4] + 4'd3 : bcd_i[4*d +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bin_o  <= bin_i;
      bcd_o  <= {adj[4*DIGITS-2:0], bin_i[K]};
      side_o <= side_i;
    end
  end

  assign valid_o = valid_q;

endmodule
`default_nettype wire

// File: sv/signed_decimal_bcd_alu.sv
// Top level of the pipelined sign-magnitude BCD arithmetic unit.
//
//   channel  dir  word
//   req_i    in   mode, a_sign, a_digits, b_sign, b_digits, b_binary
//   rsp_o    out  r_sign, r_digits, status
//
// One word enters per cycle unless the pipeline holds. A word passes the digit fold
// chain, a setup register, the core chain (one bit of multiply and divide per cell), a
// result register and the BCD conversion chain (one bit per cell). AW is the binary
// width of 10**DIGITS - 1 and W is the larger of AW and 48. Reset clears only the valid
// bits. When a result waits on rsp_o the whole pipeline holds and req_i.ready is low.
`default_nettype none
module signed_decimal_bcd_alu
  import sdba_pkg::*;
#(
  parameter int DIGITS = 15
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sdba_in_if.sink   req_i,
  sdba_out_if.source rsp_o
);

  localparam logic [63:0] MOD = pow10(DIGITS);
  localparam int AW  = $clog2(MOD);
  localparam int W   = (AW > NW) ? AW : NW;
  localparam int DW  = 4 * DIGITS;
  localparam int SW1 = 3 + 2 + 2 + NW;
  localparam int SW2 = $bits(ctl_t) + AW + 1;
  localparam int SW3 = 4;

  logic en;

  // Digit fold chain.
  logic          fv     [DIGITS+1];
  logic [DW-1:0] fa_raw [DIGITS+1];
  logic [DW-1:0] fb_raw [DIGITS+1];
  logic [AW-1:0] fa_acc [DIGITS+1];
  logic [AW-1:0] fb_acc [DIGITS+1];
  logic          fa_bad [DIGITS+1];
  logic          fb_bad [DIGITS+1];
  logic [SW1-1:0] fside [DIGITS+1];

  logic [63:0] a_ext, b_ext;

  assign en          = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;

  assign a_ext     = 64'(req_i.a_digits);
  assign b_ext     = 64'(req_i.b_digits);
  assign fv[0]     = req_i.valid;
  assign fa_raw[0] = a_ext[DW-1:0];
  assign fb_raw[0] = b_ext[DW-1:0];
  assign fa_acc[0] = '0;
  assign fb_acc[0] = '0;
  assign fa_bad[0] = 1'b0;
  assign fb_bad[0] = 1'b0;
  assign fside[0]  = {req_i.mode, req_i.a_sign, req_i.b_sign, req_i.b_binary};

  for (genvar j = 0; j < DIGITS; j++) begin : g_dec
    sdba_dec_cell #(.DIGITS(DIGITS), .IDX(DIGITS-1-j), .AW(AW), .SW(SW1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (fv[j]),
      .a_raw_i (fa_raw[j]),
      .b_raw_i (fb_raw[j]),
      .acc_a_i (fa_acc[j]),
      .acc_b_i (fb_acc[j]),
      .bad_a_i (fa_bad[j]),
      .bad_b_i (fb_bad[j]),
      .side_i  (fside[j]),
      .valid_o (fv[j+1]),
      .a_raw_o (fa_raw[j+1]),
      .b_raw_o (fb_raw[j+1]),
      .acc_a_o (fa_acc[j+1]),
      .acc_b_o (fb_acc[j+1]),
      .bad_a_o (fa_bad[j+1]),
      .bad_b_o (fb_bad[j+1]),
      .side_o  (fside[j+1])
    );
  end

  // Operand setup.
  logic [2:0]    s_mode;
  logic [1:0]    s_as, s_bs;
  logic [NW-1:0] s_n, s_nm;
  logic [AW-1:0] s_am, s_bm;
  logic          s_aneg, s_bneg, s_nneg;
  logic          s_addneg;
  logic [AW:0]   s_addmag;
  ctl_t          s_ctl;

  always_comb begin
    s_mode = fside[DIGITS][SW1-1 -: 3];
    s_as   = fside[DIGITS][NW+3:NW+2];
    s_bs   = fside[DIGITS][NW+1:NW];
    s_n    = fside[DIGITS][NW-1:0];
    s_aneg = s_as[1];
    s_bneg = s_bs[1] ^ (s_mode == M_SUB);
    s_nneg = s_n[NW-1];
    s_nm   = s_nneg ? ~s_n + NW'(1) : s_n;
    s_am   = (s_as == 2'd0) ? '0 : fa_acc[DIGITS];
    s_bm   = (s_bs == 2'd0) ? '0 : fb_acc[DIGITS];
    if (s_am == '0) begin
      s_addneg = s_bneg;
      s_addmag = {1'b0, s_bm};
    end else if (s_bm == '0) begin
      s_addneg = s_aneg;
      s_addmag = {1'b0, s_am};
    end else if (s_aneg == s_bneg) begin
      s_addneg = s_aneg;
      s_addmag = {1'b0, s_am} + {1'b0, s_bm};
    end else if (s_am >= s_bm) begin
      s_addneg = s_aneg;
      s_addmag = {1'b0, s_am - s_bm};
    end else begin
      s_addneg = s_bneg;
      s_addmag = {1'b0, s_bm - s_am};
    end
    s_ctl.mode   = s_mode;
    s_ctl.aneg   = s_aneg;
    s_ctl.nneg   = s_nneg;
    s_ctl.err    = (s_mode > M_CONV) ||
                   ((s_mode != M_CONV) &&
                    (fa_bad[DIGITS] || ((s_mode <= M_SUB) && fb_bad[DIGITS])));
    s_ctl.div0   = (s_nm == '0);
    s_ctl.addovf = s_addmag >= (AW+1)'(MOD);
    s_ctl.addneg = s_addneg;
  end

  logic           cv   [W+1];
  logic [AW-1:0]  cr   [W+1];
  logic           covf [W+1];
  logic [W-1:0]   crem [W+1];
  logic [W-1:0]   cq   [W+1];
  logic [W-1:0]   cdvd [W+1];
  logic [W-1:0]   cdvs [W+1];
  logic [AW-1:0]  cma  [W+1];
  logic [NW-1:0]  cmn  [W+1];
  logic [SW2-1:0] cside[W+1];

  logic           setup_v_q;
  logic [W-1:0]   dvd_q, dvs_q;
  logic [AW-1:0]  mula_q;
  logic [NW-1:0]  muln_q;
  logic [SW2-1:0] sside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_v_q <= 1'b0;
    end else if (en) begin
      setup_v_q <= fv[DIGITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvd_q   <= (s_mode == M_CONV) ? W'(s_nm) : W'(s_am);
      dvs_q   <= (s_mode == M_CONV) ? W'(MOD) : W'(s_nm);
      mula_q  <= s_am;
      muln_q  <= s_nm;
      sside_q <= {s_ctl, s_addmag};
    end
  end

  assign cv[0]    = setup_v_q;
  assign cr[0]    = '0;
  assign covf[0]  = 1'b0;
  assign crem[0]  = '0;
  assign cq[0]    = '0;
  assign cdvd[0]  = dvd_q;
  assign cdvs[0]  = dvs_q;
  assign cma[0]   = mula_q;
  assign cmn[0]   = muln_q;
  assign cside[0] = sside_q;

  for (genvar j = 0; j < W; j++) begin : g_core
    sdba_core_cell #(.DIGITS(DIGITS), .W(W), .K(W-1-j), .SW(SW2)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[j]),
      .r_i     (cr[j]),
      .ovf_i   (covf[j]),
      .rem_i   (crem[j]),
      .q_i     (cq[j]),
      .dvd_i   (cdvd[j]),
      .dvs_i   (cdvs[j]),
      .mula_i  (cma[j]),
      .muln_i  (cmn[j]),
      .side_i  (cside[j]),
      .valid_o (cv[j+1]),
      .r_o     (cr[j+1]),
      .ovf_o   (covf[j+1]),
      .rem_o   (crem[j+1]),
      .q_o     (cq[j+1]),
      .dvd_o   (cdvd[j+1]),
      .dvs_o   (cdvs[j+1]),
      .mula_o  (cma[j+1]),
      .muln_o  (cmn[j+1]),
      .side_o  (cside[j+1])
    );
  end

  // Result selection.
  ctl_t          e_ctl;
  logic [AW:0]   e_addmag;
  logic [AW-1:0] e_mag;
  logic          e_neg;
  status_e       e_st;
  logic [1:0]    e_sign;

  always_comb begin
    e_ctl    = cside[W][SW2-1 -: $bits(ctl_t)];
    e_addmag = cside[W][AW:0];
    e_mag    = '0;
    e_neg    = 1'b0;
    e_st     = ST_OK;
    case (e_ctl.mode)
      M_ADD, M_SUB: begin
        e_mag = e_ctl.addovf ? AW'(e_addmag - (AW+1)'(MOD)) : e_addmag[AW-1:0];
        e_neg = e_ctl.addneg;
        e_st  = e_ctl.addovf ? ST_OVF : ST_OK;
      end
      M_MUL: begin
        e_mag = cr[W];
        e_neg = e_ctl.aneg ^ e_ctl.nneg;
        e_st  = covf[W] ? ST_OVF : ST_OK;
      end
      M_DIV: begin
        e_mag = e_ctl.div0 ? '0 : cq[W][AW-1:0];
        e_neg = e_ctl.aneg ^ e_ctl.nneg;
        e_st  = e_ctl.div0 ? ST_DIV0 : ST_OK;
      end
      M_REM: begin
        e_mag = e_ctl.div0 ? '0 : crem[W][AW-1:0];
        e_neg = e_ctl.aneg;
        e_st  = e_ctl.div0 ? ST_DIV0 : ST_OK;
      end
      M_CONV: begin
        e_mag = crem[W][AW-1:0];
        e_neg = e_ctl.nneg;
        e_st  = (cq[W] != '0) ? ST_OVF : ST_OK;
      end
      default: begin
        e_mag = '0;
        e_st  = ST_BAD;
      end
    endcase
    if (e_ctl.err) begin
      e_mag = '0;
      e_st  = ST_BAD;
    end
    if (e_mag == '0) begin
      e_sign = 2'b00;
    end else begin
      e_sign = e_neg ? 2'b11 : 2'b01;
    end
  end

  logic           fin_v_q;
  logic [AW-1:0]  fin_mag_q;
  logic [SW3-1:0] fin_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= cv[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_mag_q  <= e_mag;
      fin_side_q <= {e_sign, e_st};
    end
  end

  // Binary to BCD chain.
  logic           dv    [AW+1];
  logic [AW-1:0]  dbin  [AW+1];
  logic [DW-1:0]  dbcd  [AW+1];
  logic [SW3-1:0] dside [AW+1];

  assign dv[0]    = fin_v_q;
  assign dbin[0]  = fin_mag_q;
  assign dbcd[0]  = '0;
  assign dside[0] = fin_side_q;

  for (genvar j = 0; j < AW; j++) begin : g_dd
    sdba_dd_cell #(.DIGITS(DIGITS), .AW(AW), .K(AW-1-j), .SW(SW3)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[j]),
      .bin_i   (dbin[j]),
      .bcd_i   (dbcd[j]),
      .side_i  (dside[j]),
      .valid_o (dv[j+1]),
      .bin_o   (dbin[j+1]),
      .bcd_o   (dbcd[j+1]),
      .side_o  (dside[j+1])
    );
  end

  assign rsp_o.valid    = dv[AW];
  assign rsp_o.r_digits = FW'(dbcd[AW]);
  assign rsp_o.r_sign   = dside[AW][3:2];
  assign rsp_o.status   = dside[AW][1:0];

endmodule
`default_nettype wire
